// File: hw/rtl/tae_pkg.sv
package tae_pkg;

    // curve table geometry
    localparam int CURVE_TABLE_BITS = 10;
    localparam int CURVE_N          = 1 << CURVE_TABLE_BITS;
    localparam int CURVE_SHIFT      = 16 - CURVE_TABLE_BITS;

    // divider layout: quotient bits resolved per stage
    localparam int DIV_QUO_BITS = 16;
    localparam int DIV_STEPS    = 2;
    localparam int DIV_STAGES   = DIV_QUO_BITS / DIV_STEPS;

    localparam logic [16:0] ONE_Q16 = 17'd65536;

    // animation kinds
    localparam logic [2:0] KIND_LOWER   = 3'd0;
    localparam logic [2:0] KIND_TITLE   = 3'd1;
    localparam logic [2:0] KIND_KINETIC = 3'd2;
    localparam logic [2:0] KIND_TICKER  = 3'd3;
    localparam logic [2:0] KIND_POP     = 3'd4;

    // series constants in Q30
    localparam logic [63:0] LN2_Q30    = 64'd744261118;
    localparam logic [63:0] PI_Q30     = 64'd3373259426;
    localparam logic [63:0] HALFPI_Q30 = 64'd1686629713;
    localparam logic [63:0] ANGLE_Q30  = 64'd6743098655;

    // side info carried alongside the divider
    typedef struct packed {
        logic [2:0] kind;
        logic       pos;
        logic       ge;
    } t_tag;

    typedef logic        [16:0] t_exp_tab [0:CURVE_N];
    typedef logic signed [17:0] t_sin_tab [0:CURVE_N];

    // e^z, z in Q30, result in Q30
    function automatic logic [63:0] f_exp_series(input logic [63:0] z);
        logic [63:0] sum;
        logic [63:0] term;
        sum  = 64'd1 << 30;
        term = 64'd1 << 30;
        for (int n = 1; n <= 20; n++) begin
            term = ((term * z) >> 30) / 64'(n);
            sum  = sum + term;
        end
        return sum;
    endfunction

    // sin(a), a in Q30 within [0, pi/2], result in Q30
    function automatic logic signed [63:0] f_sin_series(input logic [63:0] a);
        logic signed [63:0] sum;
        logic        [63:0] term;
        sum  = signed'(a);
        term = a;
        for (int n = 1; n <= 12; n++) begin
            term = ((((term * a) >> 30) * a) >> 30) / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1) sum = sum - signed'(term);
            else              sum = sum + signed'(term);
        end
        return (sum < 0) ? 64'sd0 : sum;
    endfunction

    function automatic t_exp_tab f_build_exp();
        t_exp_tab    tab;
        logic [63:0] m;
        logic [63:0] k;
        logic [63:0] r;
        logic [63:0] e;
        for (int i = 0; i <= CURVE_N; i++) begin
            m = 64'(10 * i);
            k = m >> CURVE_TABLE_BITS;
            r = m & 64'(CURVE_N - 1);
            if (r == 0) e = 64'd1 << 31;
            else e = f_exp_series(((64'(CURVE_N) - r) * LN2_Q30) >> CURVE_TABLE_BITS);
            tab[i] = 17'((e * 64'd65536 + (64'd1 << (30 + k))) >> (31 + k));
        end
        return tab;
    endfunction

    function automatic t_sin_tab f_build_sin();
        t_sin_tab           tab;
        logic        [63:0] a;
        logic               neg;
        logic signed [63:0] s;
        for (int i = 0; i <= CURVE_N; i++) begin
            a   = (ANGLE_Q30 * 64'(i)) >> CURVE_TABLE_BITS;
            neg = 1'b0;
            if (a >= PI_Q30) begin
                a   = a - PI_Q30;
                neg = 1'b1;
            end
            if (a > HALFPI_Q30) a = (a >= PI_Q30) ? 64'd0 : PI_Q30 - a;
            s      = (f_sin_series(a) + 64'sd8192) >>> 14;
            tab[i] = neg ? 18'(-s) : 18'(s);
        end
        return tab;
    endfunction

    localparam t_exp_tab EXP_TAB = f_build_exp();
    localparam t_sin_tab SIN_TAB = f_build_sin();

endpackage

// File: hw/rtl/tae_div.sv
module tae_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [23:0]       i_num,
    input  logic [23:0]       i_den,
    input  tae_pkg::t_tag     i_tag,
    output logic              o_valid,
    output logic [15:0]       o_quo,
    output tae_pkg::t_tag     o_tag
);
    import tae_pkg::*;

    logic        r_vld [0:DIV_STAGES-1];
    logic [23:0] r_rem [0:DIV_STAGES-1];
    logic [23:0] r_den [0:DIV_STAGES-1];
    logic [15:0] r_quo [0:DIV_STAGES-1];
    t_tag        r_tag [0:DIV_STAGES-1];

    logic        n_vld [0:DIV_STAGES-1];
    logic [23:0] n_rem [0:DIV_STAGES-1];
    logic [23:0] n_den [0:DIV_STAGES-1];
    logic [15:0] n_quo [0:DIV_STAGES-1];
    t_tag        n_tag [0:DIV_STAGES-1];

    // one restoring step: shift in a zero, subtract when it fits
    function automatic logic [24:0] f_step(input logic [23:0] rem, input logic [23:0] den);
        logic [24:0] t;
        t = {rem, 1'b0};
        if (t >= {1'b0, den}) return {1'b1, 24'(t - {1'b0, den})};
        return {1'b0, t[23:0]};
    endfunction

    // each stage resolves DIV_STEPS quotient bits
    always_comb begin
        logic [24:0] st;
        logic [23:0] rem;
        logic [15:0] quo;
        for (int s = 0; s < DIV_STAGES; s++) begin
            if (s == 0) begin
                n_vld[s] = i_valid;
                n_den[s] = i_den;
                n_tag[s] = i_tag;
                rem      = i_num;
                quo      = '0;
            end else begin
                n_vld[s] = r_vld[s-1];
                n_den[s] = r_den[s-1];
                n_tag[s] = r_tag[s-1];
                rem      = r_rem[s-1];
                quo      = r_quo[s-1];
            end
            for (int b = 0; b < DIV_STEPS; b++) begin
                st  = f_step(rem, n_den[s]);
                rem = st[23:0];
                quo = {quo[14:0], st[24]};
            end
            n_rem[s] = rem;
            n_quo[s] = quo;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < DIV_STAGES; s++) begin
            if (!i_rst_n) r_vld[s] <= 1'b0;
            else if (i_en) r_vld[s] <= n_vld[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_rem[s] <= n_rem[s];
                r_den[s] <= n_den[s];
                r_quo[s] <= n_quo[s];
                r_tag[s] <= n_tag[s];
            end
        end
    end

    assign o_valid = r_vld[DIV_STAGES-1];
    assign o_quo   = r_quo[DIV_STAGES-1];
    assign o_tag   = r_tag[DIV_STAGES-1];

endmodule

// File: hw/rtl/tae_ease.sv
module tae_ease (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [16:0]        i_p,
    input  logic [2:0]         i_kind,
    output logic               o_valid,
    output logic signed [18:0] o_x,
    output logic [15:0]        o_y,
    output logic [16:0]        o_scale,
    output logic [16:0]        o_opac
);
    import tae_pkg::*;

    // stage 1
    logic        r1_v;
    logic [2:0]  r1_kind;
    logic [16:0] r1_p;

    // stage 2
    logic               r2_v;
    logic [2:0]         r2_kind;
    logic [16:0]        r2_w;
    logic [32:0]        r2_ww;
    logic [41:0]        r2_m3;
    logic [42:0]        r2_m6;
    logic [16:0]        r2_r5;
    logic [16:0]        r2_r10;
    logic signed [17:0] r2_sin;

    // stage 3
    logic               r3_v;
    logic [2:0]         r3_kind;
    logic [16:0]        r3_w;
    logic [16:0]        r3_r10;
    logic [49:0]        r3_www;
    logic [49:0]        r3_ba;
    logic signed [35:0] r3_prod;
    logic [16:0]        r3_u5;
    logic [33:0]        r3_u5sq;
    logic [16:0]        r3_r203;
    logic [16:0]        r3_r103;
    logic [16:0]        r3_exp;

    // stage 4
    logic               r4_v;
    logic [2:0]         r4_kind;
    logic [16:0]        r4_w;
    logic [16:0]        r4_r10;
    logic [50:0]        r4_bb;
    logic [49:0]        r4_ba;
    logic [16:0]        r4_d;
    logic [16:0]        r4_d5;
    logic [16:0]        r4_u203;
    logic [33:0]        r4_u203sq;
    logic signed [19:0] r4_wob;
    logic [16:0]        r4_expo;

    // stage 5
    logic               r5_v;
    logic [2:0]         r5_kind;
    logic [16:0]        r5_r10;
    logic [17:0]        r5_bq;
    logic [15:0]        r5_y;
    logic [16:0]        r5_d5;
    logic [16:0]        r5_d203;
    logic signed [34:0] r5_ws;
    logic signed [18:0] r5_x;
    logic [16:0]        r5_expo;

    // stage 6 (output)
    logic               r6_v;
    logic signed [18:0] r6_x;
    logic [15:0]        r6_y;
    logic [16:0]        r6_scale;
    logic [16:0]        r6_opac;

    // stage-2 next values
    logic [16:0] n2_w;
    logic [20:0] n2_p10;
    logic [21:0] n2_p20;
    logic [19:0] n2_p5;

    // stage-3 next values
    logic [20:0] n3_r103_raw;
    logic [20:0] n3_r203_raw;
    logic [16:0] n3_r103;
    logic [16:0] n3_r203;
    logic [16:0] n3_u5;

    // stage-4 next values
    logic [16:0] n4_u203;

    // stage-5 next values
    logic signed [51:0] n5_b;
    logic [35:0]        n5_ymul;
    logic [35:0]        n5_xmul;

    // stage-6 next values
    logic [31:0]        n6_tmul;
    logic [17:0]        n6_title;
    logic signed [18:0] n6_pop;
    logic signed [18:0] n6_scale;
    logic signed [18:0] n6_x;
    logic [15:0]        n6_y;
    logic [16:0]        n6_opac;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
        end
    end

    // progress capture
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_kind <= i_kind;
            r1_p    <= i_p;
        end
    end

    // remaining time, square, ramp products, wobble table read
    always_comb begin
        n2_w   = ONE_Q16 - r1_p;
        n2_p5  = 20'({r1_p, 2'b0}) + 20'(r1_p);
        n2_p10 = 21'({r1_p, 3'b0}) + 21'({r1_p, 1'b0});
        n2_p20 = {n2_p10, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_kind <= r1_kind;
            r2_w    <= n2_w;
            r2_ww   <= 33'(n2_w * n2_w);
            r2_m3   <= 42'(n2_p10 * 21'd699051);
            r2_m6   <= 43'(n2_p20 * 22'd1398102);
            r2_r5   <= (n2_p5 > 20'(ONE_Q16)) ? ONE_Q16 : n2_p5[16:0];
            r2_r10  <= (n2_p10 > 21'(ONE_Q16)) ? ONE_Q16 : n2_p10[16:0];
            r2_sin  <= SIN_TAB[r1_p[16:CURVE_SHIFT]];
        end
    end

    // ramp division by three, cube and back terms, decay table read
    always_comb begin
        n3_r103_raw = 21'(r2_m3 >> 21);
        n3_r203_raw = 21'(r2_m6 >> 22);
        n3_r103     = (n3_r103_raw > 21'(ONE_Q16)) ? ONE_Q16 : n3_r103_raw[16:0];
        n3_r203     = (n3_r203_raw > 21'(ONE_Q16)) ? ONE_Q16 : n3_r203_raw[16:0];
        n3_u5       = ONE_Q16 - r2_r5;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_kind <= r2_kind;
            r3_w    <= r2_w;
            r3_r10  <= r2_r10;
            r3_www  <= 50'(r2_ww * r2_w);
            r3_ba   <= 50'(r2_ww * 17'd111515);
            r3_prod <= 36'(r2_sin * signed'({1'b0, r2_w}));
            r3_u5   <= n3_u5;
            r3_u5sq <= 34'(n3_u5 * n3_u5);
            r3_r203 <= n3_r203;
            r3_r103 <= n3_r103;
            r3_exp  <= EXP_TAB[n3_r103[16:CURVE_SHIFT]];
        end
    end

    // cubic ease terms, wobble envelope, decay ease
    assign n4_u203 = ONE_Q16 - r3_r203;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_kind   <= r3_kind;
            r4_w      <= r3_w;
            r4_r10    <= r3_r10;
            r4_bb     <= 51'(r3_www[49:16] * 18'd177051);
            r4_ba     <= r3_ba;
            r4_d      <= 17'(r3_www >> 32);
            r4_d5     <= 17'(51'(r3_u5sq * r3_u5) >> 32);
            r4_u203   <= n4_u203;
            r4_u203sq <= 34'(n4_u203 * n4_u203);
            r4_wob    <= 20'(r3_prod >>> 16);
            r4_expo   <= (r3_r103 == ONE_Q16) ? ONE_Q16 : ONE_Q16 - r3_exp;
        end
    end

    // overshoot curve, vertical and horizontal offsets
    always_comb begin
        n5_b    = (52'sd1 <<< 48) + signed'({2'b0, r4_ba}) - signed'({1'b0, r4_bb});
        n5_ymul = 36'(r4_d * 17'd51200);
        n5_xmul = 36'(r4_w * 19'd512000);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_kind <= r4_kind;
            r5_r10  <= r4_r10;
            r5_bq   <= (n5_b < 0) ? 18'd0 : 18'(n5_b >>> 32);
            r5_y    <= 16'(n5_ymul >> 16);
            r5_d5   <= r4_d5;
            r5_d203 <= 17'(51'(r4_u203sq * r4_u203) >> 32);
            r5_ws   <= 35'(r4_wob * 35'sd6554) + 35'sd32768;
            r5_x    <= 19'(signed'({1'b0, n5_xmul[35:16]}) - 21'sd256000);
            r5_expo <= r4_expo;
        end
    end

    // final scale math and per-kind selection
    always_comb begin
        n6_tmul  = 32'(r5_bq * 14'd13107) + 32'd32768;
        n6_title = 18'd52429 + 18'(n6_tmul >> 16);
        n6_pop   = 19'sd65536 + 19'(r5_ws >>> 16);
        n6_x     = '0;
        n6_y     = '0;
        n6_scale = 19'sd65536;
        n6_opac  = ONE_Q16;
        case (r5_kind)
            KIND_LOWER: begin
                n6_y    = r5_y;
                n6_opac = ONE_Q16 - r5_d5;
            end
            KIND_TITLE: begin
                n6_scale = signed'({1'b0, n6_title});
                n6_opac  = r5_expo;
            end
            KIND_TICKER: begin
                n6_x    = r5_x;
                n6_opac = r5_r10;
            end
            KIND_POP: begin
                n6_scale = n6_pop;
                n6_opac  = ONE_Q16 - r5_d203;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_x     <= n6_x;
            r6_y     <= n6_y;
            r6_opac  <= n6_opac;
            if (n6_scale < 0)                r6_scale <= '0;
            else if (n6_scale > 19'sd131071) r6_scale <= 17'd131071;
            else                             r6_scale <= n6_scale[16:0];
        end
    end

    assign o_valid = r6_v;
    assign o_x     = r6_x;
    assign o_y     = r6_y;
    assign o_scale = r6_scale;
    assign o_opac  = r6_opac;

endmodule

// File: hw/rtl/text_animation_param_eval_top.sv
// throughput: one word per cycle; the 16-stage pipe (8 of them in the divider) moves as one
// the whole pipe holds while the output word is stalled
// reset: synchronous active-low i_rst_n clears all valid bits; payload is not reset
// curve tables are constant rom, so no setup pass is needed after reset
module text_animation_param_eval_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_anim_kind,
    input  logic [23:0]        i_time_now,
    input  logic signed [23:0] i_start_delay,
    input  logic [23:0]        i_run_length,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [18:0] o_x_offset,
    output logic [15:0]        o_y_offset,
    output logic [16:0]        o_scale_factor,
    output logic [16:0]        o_opacity
);
    import tae_pkg::*;

    logic               en;

    logic               r_in_v;
    logic [2:0]         r_in_kind;
    logic [23:0]        r_in_now;
    logic signed [23:0] r_in_delay;
    logic [23:0]        r_in_len;

    logic               r_fe_v;
    logic [23:0]        r_fe_num;
    logic [23:0]        r_fe_den;
    t_tag               r_fe_tag;

    logic signed [25:0] n_elapsed;
    logic [23:0]        n_den;
    t_tag               n_tag;

    logic               div_v;
    logic [15:0]        div_quo;
    t_tag               div_tag;
    logic [16:0]        prog;

    // pipe advances unless a finished word is held
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
            r_fe_v <= 1'b0;
        end else if (en) begin
            r_in_v <= i_valid;
            r_fe_v <= r_in_v;
        end
    end

    // input word capture
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in_kind  <= i_anim_kind;
            r_in_now   <= i_time_now;
            r_in_delay <= i_start_delay;
            r_in_len   <= i_run_length;
        end
    end

    // elapsed time, short duration fix, start and finish flags
    always_comb begin
        n_elapsed  = signed'({2'b0, r_in_now}) - 26'(r_in_delay);
        n_den      = (r_in_len <= 24'd102) ? 24'd1024 : r_in_len;
        n_tag.kind = r_in_kind;
        n_tag.pos  = (n_elapsed > 0);
        n_tag.ge   = (n_elapsed >= signed'({2'b0, n_den}));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fe_num <= n_elapsed[23:0];
            r_fe_den <= n_den;
            r_fe_tag <= n_tag;
        end
    end

    tae_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_fe_v),
        .i_num   (r_fe_num),
        .i_den   (r_fe_den),
        .i_tag   (r_fe_tag),
        .o_valid (div_v),
        .o_quo   (div_quo),
        .o_tag   (div_tag)
    );

    // clamp progress to [0,1]
    assign prog = !div_tag.pos ? 17'd0 : (div_tag.ge ? ONE_Q16 : {1'b0, div_quo});

    tae_ease u_ease (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (div_v),
        .i_p     (prog),
        .i_kind  (div_tag.kind),
        .o_valid (o_valid),
        .o_x     (o_x_offset),
        .o_y     (o_y_offset),
        .o_scale (o_scale_factor),
        .o_opac  (o_opacity)
    );

endmodule

// File: bench/tae_checker.sv
`timescale 1ns / 1ps

// watches both channels, predicts each result word and compares in order
module tae_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_in_stall,
    input  logic [2:0]         i_anim_kind,
    input  logic [23:0]        i_time_now,
    input  logic signed [23:0] i_start_delay,
    input  logic [23:0]        i_run_length,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [18:0] i_x_offset,
    input  logic [15:0]        i_y_offset,
    input  logic [16:0]        i_scale_factor,
    input  logic [16:0]        i_opacity,
    output int                 o_fail_count,
    output int                 o_pending
);
    import tae_pkg::*;

    typedef struct packed {
        logic signed [18:0] x;
        logic [15:0]        y;
        logic [16:0]        scale;
        logic [16:0]        opac;
    } t_pose;

    t_pose      pose_q[$];
    t_exp_tab   exp_rom;
    t_sin_tab   sin_rom;

    // local copies of the curve tables, built by series like the hardware rom
    function automatic longint unsigned exp_sum(longint unsigned z);
        longint unsigned s, t;
        s = 64'd1 << 30;
        t = 64'd1 << 30;
        for (int n = 1; n <= 20; n++) begin
            t = ((t * z) >> 30) / n;
            s += t;
        end
        return s;
    endfunction

    function automatic longint sin_sum(longint unsigned a);
        longint s;
        longint unsigned t;
        s = longint'(a);
        t = a;
        for (int n = 1; n <= 12; n++) begin
            t = ((((t * a) >> 30) * a) >> 30) / ((2 * n) * (2 * n + 1));
            if (n % 2 == 1) s -= longint'(t);
            else s += longint'(t);
        end
        return s < 0 ? 0 : s;
    endfunction

    initial begin
        longint unsigned m, k, r, e, a;
        longint s;
        logic neg;
        for (int i = 0; i <= CURVE_N; i++) begin
            m = 10 * i;
            k = m >> CURVE_TABLE_BITS;
            r = m & (CURVE_N - 1);
            e = (r == 0) ? (64'd1 << 31)
                : exp_sum(((CURVE_N - r) * 64'd744261118) >> CURVE_TABLE_BITS);
            exp_rom[i] = 17'((e * 65536 + (64'd1 << (30 + k))) >> (31 + k));
            a = (64'd6743098655 * i) >> CURVE_TABLE_BITS;
            neg = 1'b0;
            if (a >= 64'd3373259426) begin
                a -= 64'd3373259426;
                neg = 1'b1;
            end
            if (a > 64'd1686629713) a = (a >= 64'd3373259426) ? 0 : 64'd3373259426 - a;
            s = (sin_sum(a) + 8192) >>> 14;
            sin_rom[i] = neg ? 18'(-s) : 18'(s);
        end
    end

    function automatic longint rom_index(longint q);
        longint ix;
        ix = q >> CURVE_SHIFT;
        return ix > CURVE_N ? CURVE_N : ix;
    endfunction

    function automatic longint cubic_out(longint q);
        longint unsigned u;
        u = 65536 - q;
        return 65536 - longint'((u * u * u) >> 32);
    endfunction

    function automatic longint fade(longint p, longint num, longint den);
        longint v;
        v = (p * num) / den;
        return v > 65536 ? 65536 : v;
    endfunction

    function automatic t_pose eval_pose(logic [2:0] kind, logic [23:0] now,
                                        logic signed [23:0] delay, logic [23:0] len);
        longint dur, elapsed, p, x, y, scale, opac, v, b, bq, prod, w, t, f;
        t_pose res;
        x = 0; y = 0; scale = 65536; opac = 65536; p = 0;
        dur = (len <= 102) ? 1024 : len;
        elapsed = longint'(now) - longint'(delay);
        if (elapsed > 0) begin
            p = (elapsed << 16) / dur;
            if (p > 65536) p = 65536;
        end
        case (kind)
            KIND_LOWER: begin
                y = ((65536 - cubic_out(p)) * 51200) >>> 16;
                opac = cubic_out(fade(p, 5, 1));
            end
            KIND_TITLE: begin
                v = 65536 - p;
                b = 64'sd1 << 48;
                b += 111515 * v * v;
                b -= 177051 * ((v * v * v) >>> 16);
                bq = b < 0 ? 0 : (b >>> 32);
                f = fade(p, 10, 3);
                opac = (f >= 65536) ? 65536 : 65536 - exp_rom[rom_index(f)];
                scale = 52429 + ((bq * 13107 + 32768) >>> 16);
            end
            KIND_TICKER: begin
                x = (((65536 - p) * 512000) >>> 16) - 256000;
                opac = fade(p, 10, 1);
            end
            KIND_POP: begin
                prod = longint'(sin_rom[rom_index(p)]) * (65536 - p);
                w = ((prod + (64'sd1 << 33)) >>> 16) - (64'sd1 << 17);
                t = w * 6554 + (64'sd1 << 29) + 32768;
                scale = 65536 + ((t >>> 16) - (64'sd1 << 13));
                opac = cubic_out(fade(p, 20, 3));
            end
            default: ;
        endcase
        if (x < -256000) x = -256000;
        if (x > 256000) x = 256000;
        if (y < 0) y = 0;
        if (y > 51200) y = 51200;
        if (scale < 0) scale = 0;
        if (scale > 131071) scale = 131071;
        if (opac < 0) opac = 0;
        if (opac > 65536) opac = 65536;
        res.x = 19'(x);
        res.y = 16'(y);
        res.scale = 17'(scale);
        res.opac = 17'(opac);
        return res;
    endfunction

    initial o_fail_count = 0;
    initial o_pending = 0;

    // queue accepted input words, compare accepted result words
    always @(posedge i_clk) begin
        t_pose want, got;
        if (i_rst_n && i_valid && !i_in_stall)
            pose_q.push_back(eval_pose(i_anim_kind, i_time_now, i_start_delay, i_run_length));
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            got = {i_x_offset, i_y_offset, i_scale_factor, i_opacity};
            if (pose_q.size() == 0) begin
                o_fail_count <= o_fail_count + 1;
                if (o_fail_count < 10) $display("unexpected result word %h", got);
            end else begin
                want = pose_q.pop_front();
                if (want != got) begin
                    o_fail_count <= o_fail_count + 1;
                    if (o_fail_count < 10)
                        $display("mismatch: exp x=%0d y=%0d s=%0d o=%0d got x=%0d y=%0d s=%0d o=%0d",
                                 want.x, want.y, want.scale, want.opac,
                                 got.x, got.y, got.scale, got.opac);
                end
            end
        end
        o_pending <= pose_q.size();
    end
endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import tae_pkg::*;

    localparam int RAND_WORDS = 1200;
    localparam int CALM_WORDS = 200;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [2:0]         i_anim_kind = '0;
    logic [23:0]        i_time_now = '0;
    logic signed [23:0] i_start_delay = '0;
    logic [23:0]        i_run_length = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [18:0] o_x_offset;
    logic [15:0]        o_y_offset;
    logic [16:0]        o_scale_factor;
    logic [16:0]        o_opacity;
    int                 fail_count;
    int                 pending;
    logic               calm = 1'b0;
    logic               hold_off = 1'b0;
    int                 run_left = 0;

    text_animation_param_eval_top dut (.*);

    tae_checker chk (
        .i_clk, .i_rst_n, .i_valid, .i_in_stall(o_stall), .i_anim_kind, .i_time_now,
        .i_start_delay, .i_run_length, .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_x_offset(o_x_offset), .i_y_offset(o_y_offset),
        .i_scale_factor(o_scale_factor), .i_opacity(o_opacity),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // offer one word, sometimes with a random idle burst before it
    task automatic send_word(logic [2:0] kind, logic [23:0] now,
                             logic [23:0] delay, logic [23:0] len);
        int gap;
        gap = (!calm && $urandom_range(3) == 0) ? $urandom_range(1, 7) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_anim_kind <= kind;
        i_time_now <= now;
        i_start_delay <= delay;
        i_run_length <= len;
        do @(posedge i_clk); while (o_stall);
    endtask

    // receiver stall bursts between busy stretches, plus one long hold-off; no stalls once calm
    always @(posedge i_clk) begin
        if (hold_off) begin
            i_stall  <= 1'b1;
            run_left <= 0;
        end else if (calm) begin
            i_stall <= 1'b0;
        end else if (run_left > 0) begin
            run_left <= run_left - 1;
        end else if (i_stall) begin
            i_stall  <= 1'b0;
            run_left <= $urandom_range(0, 11);
        end else begin
            i_stall  <= 1'b1;
            run_left <= $urandom_range(0, 6);
        end
    end

    initial begin
        hold_off <= 1'b1;
        repeat (300) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        #50ms;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        logic [23:0] now, len;
        logic [23:0] delay;
        int guard;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: every kind, short and long durations, not started, finished
        for (int k = 0; k < 8; k++) begin
            send_word(3'(k), 24'd0, 24'd0, 24'd0);
            send_word(3'(k), 24'd512, 24'd0, 24'd102);
            send_word(3'(k), 24'hFFFFFF, 24'h800000, 24'hFFFFFF);
        end
        send_word(KIND_POP, 24'd0, 24'h7FFFFF, 24'd103);
        // random: mostly animations in progress, some far outside
        for (int n = 0; n < RAND_WORDS; n++) begin
            if (n == RAND_WORDS - CALM_WORDS) calm = 1'b1;
            len = ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 8000));
            delay = 24'($urandom);
            if ($urandom_range(3) != 0) begin
                delay = 24'($urandom_range(0, 4000000));
                now = delay + 24'($urandom_range(0, len + 200));
            end else now = 24'($urandom);
            send_word(3'($urandom_range(0, 7)), now, delay, len);
        end
        i_valid <= 1'b0;
        guard = 0;
        while (pending != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end
endmodule
